// ===== hdl/eht_pkg.sv =====
package eht_pkg;

    localparam int SampleW = 8;
    localparam int CountW  = 13;
    localparam int RunW    = 8;
    localparam int PosW    = 13;
    localparam int CfgW    = 13;
    localparam int CfgIdxW = 2;
    localparam int NumVals = 1 << SampleW;

    localparam logic [RunW-1:0]   RunMax   = {RunW{1'b1}};
    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    localparam logic [RunW-1:0] RunCutoffRst  = RunW'(16);
    localparam logic [PosW-1:0] WindowLenRst  = PosW'(512);
    localparam logic [CfgW-1:0] PropCutoffRst = CfgW'(64);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_RUN_CUTOFF  = 2'd0,
        CFG_WINDOW_LEN  = 2'd1,
        CFG_PROP_CUTOFF = 2'd2
    } t_cfg_index;

endpackage

// ===== hdl/eht_ram.sv =====
module eht_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/entropy_health_test_core.sv =====
// Repetition count and adaptive proportion health checks on raw entropy bytes.
// One word (sample, last) is taken every cycle unless o_in_stall is high; its
// value count is read-modified-written through a 256 x 13 RAM, and a buffer's
// verdict is registered into the output register as its last word leaves the
// input register. Input stall rises only when a last word finds the previous
// verdict not yet taken. Counts are cleared at each window and buffer start by
// a bank of 256 per-value valid flops, so no clearing pass is needed after
// reset. Configuration must be written while the block is idle (unchecked).
module entropy_health_test_core
    import eht_pkg::*;
#(
    parameter int MAX_WINDOW = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgW-1:0]    i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [SampleW-1:0] i_sample,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_failed
);

    localparam logic [16:0] MaxWin = 17'(MAX_WINDOW);

    logic [RunW-1:0]    r_run_cutoff;
    logic [PosW-1:0]    r_window_len;
    logic [CfgW-1:0]    r_prop_cutoff;

    logic               r_in_valid;
    logic [SampleW-1:0] r_in_sample;
    logic               r_in_last;
    logic               r_fwd_hit;
    logic [CountW-1:0]  r_fwd_data;

    logic [SampleW-1:0] r_prev;
    logic [RunW-1:0]    r_run;
    logic [PosW-1:0]    r_pos;
    logic [NumVals-1:0] r_cnt_vld;
    logic               r_fail;
    logic               r_buf_start;
    logic               r_out_valid;
    logic               r_out_failed;

    logic               advance;
    logic               accept;
    logic               win_start;
    logic [CountW-1:0]  ram_rd_data;
    logic [CountW-1:0]  cnt_old;
    logic [CountW-1:0]  n_count;
    logic [RunW-1:0]    n_run;
    logic [PosW-1:0]    eff_window;
    logic [PosW:0]      pos_inc;
    logic [PosW-1:0]    n_pos;
    logic [NumVals-1:0] n_cnt_vld;
    logic               n_fail;

    assign advance    = r_in_valid && !(r_in_last && r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;
    assign win_start  = r_buf_start || (r_pos == '0);

    eht_ram #(
        .WIDTH(CountW),
        .DEPTH(NumVals)
    ) u_count_ram (
        .i_clk    (i_clk),
        .i_wr_en  (advance),
        .i_wr_addr(r_in_sample),
        .i_wr_data(n_count),
        .i_rd_en  (accept),
        .i_rd_addr(i_sample),
        .o_rd_data(ram_rd_data)
    );

    always_comb begin
        // bypass the RAM when the previous word wrote this value as we read it
        if (win_start || !r_cnt_vld[r_in_sample]) begin
            cnt_old = '0;
        end else if (r_fwd_hit) begin
            cnt_old = r_fwd_data;
        end else begin
            cnt_old = ram_rd_data;
        end
        n_count = (cnt_old == CountMax) ? cnt_old : cnt_old + CountW'(1);

        if (r_buf_start || (r_in_sample != r_prev)) begin
            n_run = RunW'(1);
        end else if (r_run == RunMax) begin
            n_run = r_run;
        end else begin
            n_run = r_run + RunW'(1);
        end

        if (r_window_len == '0) begin
            eff_window = PosW'(1);
        end else if ({4'b0, r_window_len} > MaxWin) begin
            eff_window = MaxWin[PosW-1:0];
        end else begin
            eff_window = r_window_len;
        end
        pos_inc = {1'b0, win_start ? {PosW{1'b0}} : r_pos} + (PosW+1)'(1);
        n_pos   = (pos_inc >= {1'b0, eff_window}) ? '0 : pos_inc[PosW-1:0];

        n_cnt_vld = win_start ? '0 : r_cnt_vld;
        n_cnt_vld[r_in_sample] = 1'b1;

        n_fail = (r_buf_start ? 1'b0 : r_fail)
               || (n_run >= r_run_cutoff)
               || (n_count > r_prop_cutoff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_cutoff  <= RunCutoffRst;
            r_window_len  <= WindowLenRst;
            r_prop_cutoff <= PropCutoffRst;
            r_in_valid    <= 1'b0;
            r_fwd_hit     <= 1'b0;
            r_prev        <= '0;
            r_run         <= '0;
            r_pos         <= '0;
            r_cnt_vld     <= '0;
            r_fail        <= 1'b0;
            r_buf_start   <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_RUN_CUTOFF:  r_run_cutoff  <= i_cfg_data[RunW-1:0];
                    CFG_WINDOW_LEN:  r_window_len  <= i_cfg_data[PosW-1:0];
                    CFG_PROP_CUTOFF: r_prop_cutoff <= i_cfg_data;
                    default: ;
                endcase
            end

            if (accept) begin
                r_in_valid <= 1'b1;
                r_fwd_hit  <= advance && (r_in_sample == i_sample);
            end else if (advance) begin
                r_in_valid <= 1'b0;
                r_fwd_hit  <= 1'b0;
            end

            if (advance) begin
                r_prev      <= r_in_sample;
                r_run       <= n_run;
                r_pos       <= n_pos;
                r_cnt_vld   <= n_cnt_vld;
                r_fail      <= n_fail;
                r_buf_start <= r_in_last;
            end

            // hold the verdict until taken
            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_sample <= i_sample;
            r_in_last   <= i_last;
            r_fwd_data  <= n_count;
        end
        if (advance && r_in_last) begin
            r_out_failed <= n_fail;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_failed    = r_out_failed;

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in_last && r_out_valid))
        else $error("input stalled without a blocked last word");

    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_buf_start && r_out_valid))
        else $error("last word did not rearm or post a verdict");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_run != '0) && r_cnt_vld[r_prev])
        else $error("run length or count valid bit lost after a word");

    a_fwd_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_in_valid)
        else $error("count bypass set with no word in flight");

endmodule
